### rtl/core/bpq_pkg.sv
// ---------------------------------------------------------------------------
// bpq_pkg
// Shared types and codes for the priority bitmap ready queue.
// ---------------------------------------------------------------------------
package bpq_pkg;

	// operation codes
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_NEXT   = 2'd2;
	localparam logic [1:0] OP_ROTATE = 2'd3;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_LEVEL = 2'd1;
	localparam logic [1:0] STAT_TASK  = 2'd2;
	localparam logic [1:0] STAT_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [4:0] task_id;
		logic [5:0] level;
	} req_item_t;

	typedef struct packed {
		logic [4:0] chosen_task;
		logic [4:0] chosen_level;
		logic [1:0] status;
	} rsp_item_t;

endpackage

### rtl/core/bpq_ram.sv
// ---------------------------------------------------------------------------
// bpq_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module bpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/priority_bitmap_ready_queue_core.sv
// ---------------------------------------------------------------------------
// priority_bitmap_ready_queue_core
// Ready-queue scheduler: per-level task lists, ready bitmap, skip throttle.
// ---------------------------------------------------------------------------
// Usage:
//   A request (req) carries an opcode, a task id and a level; every request
//   yields exactly one response (rsp) with the picked task, its level and a
//   status. Both channels transfer when valid is high and stall is low.
//   One request is in flight at a time: req_stall is high from the cycle
//   after a transfer until the response is loaded into the output register.
//   Add, and any add or remove that fails its checks, goes from execute
//   straight to done; next passes the quota and pick states first. Remove
//   walks the level's list until it finds the task; rotate walks it to the
//   tail unless the level holds a single task. Every list step is a read
//   of the link memory (one read port, registered read) followed by a
//   check of the returned link.
//   Reset clears the level head valid bits, queued flags, ready bitmap, skip
//   mask and quota at once; the link memory needs no clearing.
//   While the receiver stalls, the response holds in the output register and
//   a following result waits in its final state until the register frees.
// ---------------------------------------------------------------------------
module priority_bitmap_ready_queue_core #(
	parameter int MAX_TASKS   = 32,
	parameter int LEVEL_COUNT = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  bpq_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output bpq_pkg::rsp_item_t rsp
);

	import bpq_pkg::*;

	localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int LW = $clog2(LEVEL_COUNT);
	localparam int CW = $clog2(LEVEL_COUNT + 1);
	localparam int SW = $clog2(MAX_TASKS + 1);

	typedef struct packed {
		logic          valid;
		logic [TW-1:0] id;
	} link_t;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_NEXT, S_PICK, S_RM_RD, S_RM_CHK, S_ROT_RD, S_ROT_CHK,
		S_WALK_RD, S_WALK_CHK, S_TAIL_W, S_HEAD_W, S_DONE
	} state_t;

	state_t                 state_q;
	logic [1:0]             op_q;
	logic [4:0]             tid_q;
	logic [5:0]             lvl_q;
	logic                   hv_q [LEVEL_COUNT];
	logic [TW-1:0]          hid_q [LEVEL_COUNT];
	logic [MAX_TASKS-1:0]   queued_q;
	logic [LEVEL_COUNT-1:0] ready_q;
	logic [LEVEL_COUNT-1:0] skip_q;
	logic [CW-1:0]          quota_q;
	logic [CW-1:0]          cnt_q;
	logic                   cur_v_q;
	logic [TW-1:0]          cur_q;
	logic                   prev_v_q;
	logic [TW-1:0]          prev_q;
	logic [SW-1:0]          steps_q;
	logic [LW-1:0]          pk_q;
	logic [TW-1:0]          h_q;
	logic [TW-1:0]          tail_q;
	rsp_item_t              res_q;
	logic                   rsp_valid_q;
	rsp_item_t              rsp_q;

	logic                   ram_we;
	logic [TW-1:0]          ram_waddr;
	link_t                  ram_wdata;
	logic [TW-1:0]          ram_raddr;
	link_t                  link_rd;

	logic [LW-1:0]          lidx;
	logic [TW-1:0]          tidx;
	logic                   lvl_bad;
	logic                   tid_bad;
	logic [LEVEL_COUNT-1:0] eff;
	logic [LW-1:0]          pick;
	logic [LEVEL_COUNT-1:0] lbit;
	logic [LEVEL_COUNT-1:0] pbit;
	logic                   slot_free;

	function automatic logic [LW-1:0] top_bit(input logic [LEVEL_COUNT-1:0] v);
		logic [LW-1:0] r;
		r = '0;
		for (int i = 0; i < LEVEL_COUNT; i++) begin
			if (v[i]) begin
				r = LW'(i);
			end
		end
		return r;
	endfunction

	// decode the captured request
	assign lidx    = LW'(lvl_q);
	assign tidx    = TW'(tid_q);
	assign lvl_bad = 32'(lvl_q) >= 32'(LEVEL_COUNT);
	assign tid_bad = 32'(tid_q) >= 32'(MAX_TASKS);
	assign lbit    = LEVEL_COUNT'(1) << lidx;
	assign pbit    = LEVEL_COUNT'(1) << pk_q;

	// pick among unskipped ready levels, all ready levels if none left
	always_comb begin
		eff = ready_q & ~skip_q;
		if (eff == '0) begin
			eff = ready_q;
		end
		pick = top_bit(eff);
	end

	assign slot_free = !rsp_valid_q || !rsp_stall;

	// link memory control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tidx;
		ram_wdata = '{valid: hv_q[lidx], id: hid_q[lidx]};
		ram_raddr = cur_q;
		case (state_q)
			S_EXEC: begin
				ram_we = (op_q == OP_ADD) && !lvl_bad && !tid_bad && !queued_q[tidx];
			end
			S_RM_CHK: begin
				ram_we    = (cur_q == tidx) && prev_v_q;
				ram_waddr = prev_q;
				ram_wdata = link_rd;
			end
			S_ROT_RD: begin
				ram_raddr = h_q;
			end
			S_WALK_RD: begin
				ram_raddr = tail_q;
			end
			S_TAIL_W: begin
				ram_we    = 1'b1;
				ram_waddr = tail_q;
				ram_wdata = '{valid: 1'b1, id: h_q};
			end
			S_HEAD_W: begin
				ram_we    = 1'b1;
				ram_waddr = h_q;
				ram_wdata = '0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	bpq_ram #(
		.WIDTH(TW + 1),
		.DEPTH(MAX_TASKS)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(link_rd)
	);

	// level head ids: payload, written alongside the valid bits
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && op_q == OP_ADD && !lvl_bad && !tid_bad
				&& !queued_q[tidx]) begin
			hid_q[lidx] <= tidx;
		end else if (state_q == S_RM_CHK && cur_q == tidx && !prev_v_q) begin
			hid_q[lidx] <= link_rd.id;
		end else if (state_q == S_ROT_CHK && link_rd.valid) begin
			hid_q[pk_q] <= link_rd.id;
		end
	end

	// sequencer: read, check and write back list links
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_ADD;
			tid_q       <= '0;
			lvl_q       <= '0;
			for (int i = 0; i < LEVEL_COUNT; i++) begin
				hv_q[i] <= 1'b0;
			end
			queued_q    <= '0;
			ready_q     <= '0;
			skip_q      <= '0;
			quota_q     <= '0;
			cnt_q       <= '0;
			cur_v_q     <= 1'b0;
			cur_q       <= '0;
			prev_v_q    <= 1'b0;
			prev_q      <= '0;
			steps_q     <= '0;
			pk_q        <= '0;
			h_q         <= '0;
			tail_q      <= '0;
			res_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// drop the response once it transfers, unless a new one loads
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q    <= req.opcode;
						tid_q   <= req.task_id;
						lvl_q   <= req.level;
						res_q   <= '0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (op_q)
						OP_ADD, OP_REMOVE: begin
							state_q <= S_DONE;
							if (lvl_bad) begin
								res_q.status <= STAT_LEVEL;
							end else if (tid_bad || queued_q[tidx] == (op_q == OP_ADD)) begin
								res_q.status <= STAT_TASK;
							end else if (op_q == OP_ADD) begin
								hv_q[lidx]     <= 1'b1;
								queued_q[tidx] <= 1'b1;
								if (!ready_q[lidx]) begin
									ready_q <= ready_q | lbit;
									cnt_q   <= cnt_q + CW'(1);
								end
							end else begin
								cur_v_q  <= hv_q[lidx];
								cur_q    <= hid_q[lidx];
								prev_v_q <= 1'b0;
								steps_q  <= '0;
								state_q  <= S_RM_RD;
							end
						end
						OP_NEXT: begin
							state_q <= S_NEXT;
						end
						default: begin
							state_q <= S_PICK;
						end
					endcase
				end
				S_NEXT: begin
					// count the quota down, release the skip mask at zero
					if (skip_q != '0 && quota_q != '0) begin
						quota_q <= quota_q - CW'(1);
						if (quota_q == CW'(1)) begin
							skip_q <= '0;
						end
					end
					state_q <= S_PICK;
				end
				S_PICK: begin
					state_q <= S_DONE;
					if (op_q == OP_NEXT && (ready_q & ~skip_q) == '0) begin
						skip_q <= '0;
					end
					if (ready_q == '0) begin
						res_q.status <= STAT_EMPTY;
					end else if (op_q == OP_NEXT) begin
						res_q.chosen_task  <= 5'(hid_q[pick]);
						res_q.chosen_level <= 5'(pick);
					end else begin
						pk_q    <= pick;
						h_q     <= hid_q[pick];
						state_q <= S_ROT_RD;
					end
				end
				S_RM_RD: begin
					if (!cur_v_q || steps_q == SW'(MAX_TASKS)) begin
						res_q.status <= STAT_TASK;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_RM_CHK;
					end
				end
				S_RM_CHK: begin
					if (cur_q == tidx) begin
						// unlink the found task
						queued_q[tidx] <= 1'b0;
						if (!prev_v_q) begin
							hv_q[lidx] <= link_rd.valid;
							if (!link_rd.valid) begin
								ready_q <= ready_q & ~lbit;
								cnt_q   <= cnt_q - CW'(1);
							end
						end
						state_q <= S_DONE;
					end else begin
						prev_v_q <= 1'b1;
						prev_q   <= cur_q;
						cur_v_q  <= link_rd.valid;
						cur_q    <= link_rd.id;
						steps_q  <= steps_q + SW'(1);
						state_q  <= S_RM_RD;
					end
				end
				S_ROT_RD: begin
					state_q <= S_ROT_CHK;
				end
				S_ROT_CHK: begin
					if (!link_rd.valid) begin
						// single task: skip the level for one pass over the ready ones
						skip_q  <= skip_q | pbit;
						quota_q <= cnt_q;
						state_q <= S_DONE;
					end else begin
						tail_q  <= link_rd.id;
						steps_q <= '0;
						state_q <= S_WALK_RD;
					end
				end
				S_WALK_RD: begin
					state_q <= (steps_q == SW'(MAX_TASKS)) ? S_TAIL_W : S_WALK_CHK;
				end
				S_WALK_CHK: begin
					if (link_rd.valid) begin
						tail_q  <= link_rd.id;
						steps_q <= steps_q + SW'(1);
						state_q <= S_WALK_RD;
					end else begin
						state_q <= S_TAIL_W;
					end
				end
				S_TAIL_W: begin
					state_q <= S_HEAD_W;
				end
				S_HEAD_W: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/core/bpq_checker.sv
// ---------------------------------------------------------------------------
// bpq_checker
// Port-level checks for the ready-queue scheduler, bound to the scheduler core.
// ---------------------------------------------------------------------------
module bpq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input bpq_pkg::rsp_item_t rsp
);

	import bpq_pkg::*;

	// hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed or dropped");

	// one request at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is in flight");

	// no pick reported on a failed operation
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != STAT_OK |-> rsp.chosen_task == '0 && rsp.chosen_level == '0)
		else $error("nonzero pick with failure status");

	// a response never appears in the cycle right after a request transfer
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !(rsp_valid && rsp_stall) |=> !$rose(rsp_valid))
		else $error("response too early");

endmodule

bind priority_bitmap_ready_queue_core bpq_checker u_bpq_checker (.*);
